FILE: rtl/tsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the touch sample calibrator.
// Depends on nothing; every other file refers to it by scoped names.
package tsc_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int REG_W        = 12;
  localparam int BYTE_W       = 8;
  localparam int IDX_W        = 3;
  localparam int KIND_W       = 2;
  localparam int PROD_W       = 2 * REG_W;
  localparam int DIV_STEPS    = PROD_W;

  localparam logic [REG_W-1:0] LEFT_RST   = 12'd432;
  localparam logic [REG_W-1:0] RIGHT_RST  = 12'd3644;
  localparam logic [REG_W-1:0] TOP_RST    = 12'd447;
  localparam logic [REG_W-1:0] BOTTOM_RST = 12'd3455;
  localparam logic [REG_W-1:0] WIDTH_RST  = 12'd320;
  localparam logic [REG_W-1:0] HEIGHT_RST = 12'd240;

  typedef enum logic [IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_TOP    = 3'd2,
    REG_BOTTOM = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    EV_COORD = 2'd0,
    EV_START = 2'd1,
    EV_END   = 2'd2
  } ev_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_START,
    S_LAUNCH,
    S_DIV,
    S_COORD,
    S_END
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_load;
    logic div_start;
    logic load_start;
    logic load_end;
    logic load_coord;
  } cmd_t;

  typedef struct packed {
    logic no_touch;
    logic in_range;
    logic div_busy;
    logic slot_free;
  } status_t;

endpackage

FILE: rtl/tsc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on tsc_pkg for field widths.
interface tsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [tsc_pkg::BYTE_W-1:0]  x_high_byte;
  logic [tsc_pkg::BYTE_W-1:0]  x_low_byte;
  logic [tsc_pkg::BYTE_W-1:0]  y_high_byte;
  logic [tsc_pkg::BYTE_W-1:0]  y_low_byte;
  modport source (output valid, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
                  input ready);
  modport sink   (input valid, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
                  output ready);
endinterface

interface tsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tsc_pkg::KIND_W-1:0]  event_kind;
  logic [tsc_pkg::REG_W-1:0]   screen_x;
  logic [tsc_pkg::REG_W-1:0]   screen_y;
  logic                        last;
  modport source (output valid, event_kind, screen_x, screen_y, last, input ready);
  modport sink   (input valid, event_kind, screen_x, screen_y, last, output ready);
endinterface

interface tsc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tsc_pkg::IDX_W-1:0]   index;
  logic [tsc_pkg::REG_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tsc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the coordinate scaling.
// Depends on tsc_pkg for widths and step count.
module tsc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tsc_pkg::PROD_W-1:0]    dividend,
  input  logic [tsc_pkg::REG_W-1:0]     divisor,
  output logic                          busy,
  output logic [tsc_pkg::REG_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(tsc_pkg::DIV_STEPS + 1);

  logic                        busy_r, busy_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [tsc_pkg::REG_W-1:0]   rem_r, rem_nxt;
  logic [tsc_pkg::PROD_W-1:0]  quo_r, quo_nxt;
  logic [tsc_pkg::REG_W-1:0]   dvs_r, dvs_nxt;
  logic [tsc_pkg::REG_W:0]     trial;
  logic                        fits;

  assign trial = {rem_r, quo_r[tsc_pkg::PROD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(tsc_pkg::DIV_STEPS);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when the divisor fits
      rem_nxt = fits ? tsc_pkg::REG_W'(trial - {1'b0, dvs_r})
                     : tsc_pkg::REG_W'(trial);
      quo_nxt = {quo_r[tsc_pkg::PROD_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r[tsc_pkg::REG_W-1:0];

endmodule

FILE: rtl/tsc_dp.sv
`timescale 1ns / 1ps
// Datapath: calibration registers, sample unpack, edge checks, scaling, result register.
// Depends on tsc_pkg and tsc_div.
module tsc_dp #(
  parameter int ADC_BITS = tsc_pkg::ADC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsc_pkg::cmd_t                 cmd,
  output tsc_pkg::status_t              status,
  input  logic [tsc_pkg::BYTE_W-1:0]    x_high_byte,
  input  logic [tsc_pkg::BYTE_W-1:0]    x_low_byte,
  input  logic [tsc_pkg::BYTE_W-1:0]    y_high_byte,
  input  logic [tsc_pkg::BYTE_W-1:0]    y_low_byte,
  input  logic                          cfg_we,
  input  logic [tsc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tsc_pkg::REG_W-1:0]     cfg_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [tsc_pkg::KIND_W-1:0]    res_kind,
  output logic [tsc_pkg::REG_W-1:0]     res_x,
  output logic [tsc_pkg::REG_W-1:0]     res_y,
  output logic                          res_last
);

  localparam int WORD_W = 2 * tsc_pkg::BYTE_W;
  localparam int RAW_W  = (ADC_BITS >= 15) ? WORD_W : ADC_BITS + 1;
  localparam int CMP_W  = (RAW_W > tsc_pkg::REG_W) ? RAW_W : tsc_pkg::REG_W;
  localparam logic [RAW_W-1:0] NO_TOUCH = RAW_W'((32'd1 << ADC_BITS) - 32'd1);

  logic [tsc_pkg::REG_W-1:0] left_r, right_r, top_r, bottom_r, width_r, height_r;
  logic [RAW_W-1:0]          raw_x_r, raw_y_r;
  logic [WORD_W-1:0]         word_x, word_y;
  logic [CMP_W-1:0]          x_c, y_c, left_c, right_c, top_c, bottom_c;
  logic [tsc_pkg::REG_W-1:0] diff_x, diff_y, span_x, span_y;
  logic [tsc_pkg::PROD_W-1:0] prod_x_r, prod_y_r;
  logic [tsc_pkg::REG_W-1:0] span_x_r, span_y_r;
  logic                      zspan_x_r, zspan_y_r;
  logic                      busy_x, busy_y;
  logic [tsc_pkg::REG_W-1:0] quo_x, quo_y;
  logic                      valid_r;
  tsc_pkg::ev_kind_t         kind_r;
  logic [tsc_pkg::REG_W-1:0] sx_r, sy_r;
  logic                      last_r;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= tsc_pkg::LEFT_RST;
      right_r  <= tsc_pkg::RIGHT_RST;
      top_r    <= tsc_pkg::TOP_RST;
      bottom_r <= tsc_pkg::BOTTOM_RST;
      width_r  <= tsc_pkg::WIDTH_RST;
      height_r <= tsc_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (tsc_pkg::reg_idx_t'(cfg_index))
        tsc_pkg::REG_LEFT:   left_r   <= cfg_data;
        tsc_pkg::REG_RIGHT:  right_r  <= cfg_data;
        tsc_pkg::REG_TOP:    top_r    <= cfg_data;
        tsc_pkg::REG_BOTTOM: bottom_r <= cfg_data;
        tsc_pkg::REG_WIDTH:  width_r  <= cfg_data;
        tsc_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack: keep the top RAW_W bits of the 16-bit reply word
  assign word_x = {x_high_byte, x_low_byte};
  assign word_y = {y_high_byte, y_low_byte};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_x_r <= word_x[WORD_W-1:WORD_W-RAW_W];
      raw_y_r <= word_y[WORD_W-1:WORD_W-RAW_W];
    end
  end

  assign x_c      = CMP_W'(raw_x_r);
  assign y_c      = CMP_W'(raw_y_r);
  assign left_c   = CMP_W'(left_r);
  assign right_c  = CMP_W'(right_r);
  assign top_c    = CMP_W'(top_r);
  assign bottom_c = CMP_W'(bottom_r);

  assign status.no_touch = (raw_x_r == NO_TOUCH) && (raw_y_r == '0);
  assign status.in_range = !((x_c < left_c) || (x_c > right_c) ||
                             (y_c < top_c) || (y_c > bottom_c));

  // only used when in range, so the differences fit the register width
  assign diff_x = tsc_pkg::REG_W'(x_c - left_c);
  assign diff_y = tsc_pkg::REG_W'(y_c - top_c);
  assign span_x = right_r - left_r;
  assign span_y = bottom_r - top_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_x_r  <= tsc_pkg::PROD_W'(width_r) * tsc_pkg::PROD_W'(diff_x);
      prod_y_r  <= tsc_pkg::PROD_W'(height_r) * tsc_pkg::PROD_W'(diff_y);
      span_x_r  <= span_x;
      span_y_r  <= span_y;
      zspan_x_r <= (span_x == '0);
      zspan_y_r <= (span_y == '0);
    end
  end

  tsc_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_x_r),
    .divisor  (span_x_r),
    .busy     (busy_x),
    .quotient (quo_x)
  );

  tsc_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_y_r),
    .divisor  (span_y_r),
    .busy     (busy_y),
    .quotient (quo_y)
  );

  assign status.div_busy  = busy_x || busy_y;
  assign status.slot_free = !valid_r || res_ready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.load_start || cmd.load_end || cmd.load_coord) begin
      valid_r <= 1'b1;
    end else if (res_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      kind_r <= tsc_pkg::EV_START;
      sx_r   <= '0;
      sy_r   <= '0;
      last_r <= 1'b0;
    end else if (cmd.load_end) begin
      kind_r <= tsc_pkg::EV_END;
      sx_r   <= '0;
      sy_r   <= '0;
      last_r <= 1'b1;
    end else if (cmd.load_coord) begin
      kind_r <= tsc_pkg::EV_COORD;
      sx_r   <= zspan_x_r ? '0 : quo_x;
      sy_r   <= zspan_y_r ? '0 : quo_y;
      last_r <= 1'b1;
    end
  end

  assign res_valid = valid_r;
  assign res_kind  = kind_r;
  assign res_x     = sx_r;
  assign res_y     = sy_r;
  assign res_last  = last_r;

endmodule

FILE: rtl/tsc_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences capture, checks, scaling and result loads; owns the pen flag.
// Depends on tsc_pkg.
module tsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsc_pkg::status_t  status,
  output tsc_pkg::cmd_t     cmd
);

  tsc_pkg::state_t state_r, state_nxt;
  logic            pen_r, pen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsc_pkg::S_IDLE;
      pen_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pen_r   <= pen_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = tsc_pkg::S_EVAL;
      end
      tsc_pkg::S_EVAL: begin
        if (status.no_touch) begin
          state_nxt = pen_r ? tsc_pkg::S_END : tsc_pkg::S_IDLE;
        end else if (!status.in_range) begin
          state_nxt = tsc_pkg::S_IDLE;
        end else begin
          state_nxt = pen_r ? tsc_pkg::S_LAUNCH : tsc_pkg::S_START;
        end
      end
      tsc_pkg::S_START: begin
        if (status.slot_free) state_nxt = tsc_pkg::S_LAUNCH;
      end
      tsc_pkg::S_LAUNCH: state_nxt = tsc_pkg::S_DIV;
      tsc_pkg::S_DIV: begin
        if (!status.div_busy) state_nxt = tsc_pkg::S_COORD;
      end
      tsc_pkg::S_COORD: begin
        if (status.slot_free) state_nxt = tsc_pkg::S_IDLE;
      end
      tsc_pkg::S_END: begin
        if (status.slot_free) state_nxt = tsc_pkg::S_IDLE;
      end
      default: state_nxt = tsc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    pen_nxt  = pen_r;
    unique case (state_r)
      tsc_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      tsc_pkg::S_EVAL:   cmd.mul_load = 1'b1;
      tsc_pkg::S_START: begin
        if (status.slot_free) begin
          cmd.load_start = 1'b1;
          pen_nxt        = 1'b1;
        end
      end
      tsc_pkg::S_LAUNCH: cmd.div_start = 1'b1;
      tsc_pkg::S_DIV:    ;
      tsc_pkg::S_COORD:  cmd.load_coord = status.slot_free;
      tsc_pkg::S_END: begin
        if (status.slot_free) begin
          cmd.load_end = 1'b1;
          pen_nxt      = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/touch_sample_calibrator_top.sv
`timescale 1ns / 1ps
// Touch sample calibrator: unpacks raw X/Y replies, tracks pen state, scales to pixels.
// Sequence: a sample beat is captured in S_IDLE and checked in S_EVAL; a pen-end beat
// is loaded in S_END, a coordinate beat in S_COORD after S_START (when the pen goes down),
// S_LAUNCH and S_DIV, where the two 24-step restoring dividers run side by side.
// Only one sample is taken at a time: the next is accepted once back in S_IDLE, and the
// block stays busy longer while the result register is stalled.
// Reset (rst_n low, synchronous): pen up, calibration registers at their defaults.
module touch_sample_calibrator_top #(
  parameter int ADC_BITS = tsc_pkg::ADC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tsc_in_if.sink     in_bus,
  tsc_out_if.source  out_bus,
  tsc_cfg_if.sink    cfg_bus
);

  tsc_pkg::cmd_t    cmd;
  tsc_pkg::status_t status;

  // register writes are always taken; the user must send them only while idle, unchecked
  assign cfg_bus.ready = 1'b1;

  // sequencer: takes one sample beat at a time, then walks it through the datapath
  tsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: capture, edge checks, multiply, divide, and the output beat register
  tsc_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .x_high_byte (in_bus.x_high_byte),
    .x_low_byte  (in_bus.x_low_byte),
    .y_high_byte (in_bus.y_high_byte),
    .y_low_byte  (in_bus.y_low_byte),
    .cfg_we      (cfg_bus.valid),
    .cfg_index   (cfg_bus.index),
    .cfg_data    (cfg_bus.data),
    .res_valid   (out_bus.valid),
    .res_ready   (out_bus.ready),
    .res_kind    (out_bus.event_kind),
    .res_x       (out_bus.screen_x),
    .res_y       (out_bus.screen_y),
    .res_last    (out_bus.last)
  );

endmodule
